>>> hw/rtl/ppt_pkg.sv
// shared constants and register codes for the projective point transform
`default_nettype none
package ppt_pkg;
   localparam int FracBitsDefault = 16;
   localparam int CsrIndexWidth   = 3;
   localparam int CsrDataWidth    = 64;
   localparam int DivSteps        = 32;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_COEF_COL0       = 3'd0,
      CSR_COEF_COL1       = 3'd1,
      CSR_COEF_TRANSLATE  = 3'd2,
      CSR_COEF_PROJECTIVE = 3'd3,
      CSR_COEF_CORNER     = 3'd4,
      CSR_MIN_DENOMINATOR = 3'd5
   } csr_index_type;
endpackage
`default_nettype wire

>>> hw/rtl/ppt_front.sv
// products, sums and denominator clamp: three register stages
`default_nettype none
module ppt_front #(
   parameter int FRAC_BITS = ppt_pkg::FracBitsDefault,
   localparam int SW = 66 - FRAC_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire logic signed [31:0]    point_x,
   input  wire logic signed [31:0]    point_y,
   input  wire logic [63:0]           coef_col0,
   input  wire logic [63:0]           coef_col1,
   input  wire logic [63:0]           coef_translate,
   input  wire logic [63:0]           coef_projective,
   input  wire logic [31:0]           coef_corner,
   input  wire logic [30:0]           min_denominator,
   output logic [SW-1:0]              un_x,
   output logic [SW-1:0]              un_y,
   output logic [SW-1:0]              ud,
   output logic                       neg_x,
   output logic                       neg_y,
   output logic                       clamped
);
   logic signed [63:0] p_ff [6];
   logic signed [63:0] p_in [6];
   logic signed [31:0] t_ff [3];
   logic signed [SW-1:0] s_in [3];
   logic signed [SW-1:0] s_ff [3];
   logic [SW-1:0] aw;
   logic [SW-1:0] floor_w;
   logic clamp;
   logic [SW-1:0] un_x_ff, un_y_ff, ud_ff;
   logic neg_x_ff, neg_y_ff, clamped_ff;

   always_comb begin
      p_in[0] = $signed(coef_col0[31:0])       * point_x;
      p_in[1] = $signed(coef_col1[31:0])       * point_y;
      p_in[2] = $signed(coef_col0[63:32])      * point_x;
      p_in[3] = $signed(coef_col1[63:32])      * point_y;
      p_in[4] = $signed(coef_projective[31:0]) * point_x;
      p_in[5] = $signed(coef_projective[63:32]) * point_y;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 6; i++) p_ff[i] <= p_in[i];
         t_ff[0] <= $signed(coef_translate[31:0]);
         t_ff[1] <= $signed(coef_translate[63:32]);
         t_ff[2] <= $signed(coef_corner);
      end
   end

   // floor of each product, then exact sums
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s_in[k] = SW'($signed(p_ff[2*k][63:FRAC_BITS]))
                 + SW'($signed(p_ff[2*k+1][63:FRAC_BITS]))
                 + SW'(t_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) s_ff[k] <= s_in[k];
      end
   end

   always_comb begin
      floor_w = (min_denominator == 31'd0) ? SW'(1) : SW'(min_denominator);
      aw      = s_ff[2][SW-1] ? SW'(-s_ff[2]) : SW'(s_ff[2]);
      clamp   = aw <= floor_w;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         un_x_ff    <= s_ff[0][SW-1] ? SW'(-s_ff[0]) : SW'(s_ff[0]);
         un_y_ff    <= s_ff[1][SW-1] ? SW'(-s_ff[1]) : SW'(s_ff[1]);
         ud_ff      <= clamp ? floor_w : aw;
         neg_x_ff   <= s_ff[0][SW-1] ^ (!clamp && s_ff[2][SW-1]);
         neg_y_ff   <= s_ff[1][SW-1] ^ (!clamp && s_ff[2][SW-1]);
         clamped_ff <= clamp;
      end
   end

   assign un_x    = un_x_ff;
   assign un_y    = un_y_ff;
   assign ud      = ud_ff;
   assign neg_x   = neg_x_ff;
   assign neg_y   = neg_y_ff;
   assign clamped = clamped_ff;
endmodule
`default_nettype wire

>>> hw/rtl/ppt_div.sv
// pipelined restoring divider, one quotient bit per stage, saturating
`default_nettype none
module ppt_div #(
   parameter int FRAC_BITS = ppt_pkg::FracBitsDefault,
   localparam int UW = 66 - FRAC_BITS
) (
   input  wire logic            clock,
   input  wire logic            en,
   input  wire logic [UW-1:0]   un,
   input  wire logic [UW-1:0]   ud,
   input  wire logic            neg,
   output logic [31:0]          quot,
   output logic                 sat
);
   localparam int NS = ppt_pkg::DivSteps;
   localparam int SH = 32 - FRAC_BITS;
   localparam int CW = UW + SH;

   logic [UW-1:0] r_ff  [NS+1];
   logic [UW-1:0] d_ff  [NS+1];
   logic [31:0]   q_ff  [NS+1];
   logic [31:0]   dl_ff [NS+1];
   logic          ovf_ff [NS+1];
   logic          neg_ff [NS+1];
   logic [31:0]   quot_ff;
   logic          sat_ff;
   logic          sat_in;
   logic [31:0]   lim;

   // overflow when the quotient would reach 2^32
   always_ff @(posedge clock) begin
      if (en) begin
         ovf_ff[0] <= CW'(un) >= {ud, {SH{1'b0}}};
         r_ff[0]   <= UW'(un >> SH);
         dl_ff[0]  <= {un[SH-1:0], {FRAC_BITS{1'b0}}};
         d_ff[0]   <= ud;
         q_ff[0]   <= '0;
         neg_ff[0] <= neg;
      end
   end

   for (genvar s = 1; s <= NS; s++) begin : g_step
      logic [UW:0] t;
      logic        ge;
      always_comb begin
         t  = {r_ff[s-1], dl_ff[s-1][31]};
         ge = t >= {1'b0, d_ff[s-1]};
      end
      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[s]   <= ge ? UW'(t - {1'b0, d_ff[s-1]}) : UW'(t);
            q_ff[s]   <= {q_ff[s-1][30:0], ge};
            dl_ff[s]  <= {dl_ff[s-1][30:0], 1'b0};
            d_ff[s]   <= d_ff[s-1];
            ovf_ff[s] <= ovf_ff[s-1];
            neg_ff[s] <= neg_ff[s-1];
         end
      end
   end

   always_comb begin
      lim    = neg_ff[NS] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      sat_in = ovf_ff[NS] || (q_ff[NS] > lim);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sat_ff  <= sat_in;
         quot_ff <= sat_in ? lim : (neg_ff[NS] ? 32'(-q_ff[NS]) : q_ff[NS]);
      end
   end

   assign quot = quot_ff;
   assign sat  = sat_ff;
endmodule
`default_nettype wire

>>> hw/rtl/projective_point_transform.sv
// top level of the projective point transform
// Maps one signed fixed point (x, y) through a 3x3 homogeneous matrix and
// divides by w. Input transactions arrive on req_ (tdata = x low, y high),
// results leave on rsp_ (tdata = out_x low, out_y high; tuser = denominator
// clamped, saturated). Coefficients are written on the csr_ port, one
// register per write. The user must write them only while no transaction
// is in flight; the block itself does not enforce this. The pipeline has
// three stages of multiply, sum and clamp, one stage of overflow detection,
// 32 divider stages (one quotient bit each) and the output register.
// Throughput is one transaction per cycle while the receiver does not stall.
// Reset empties the pipeline and loads the identity matrix with a
// minimum denominator of one.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and req_tready falls; nothing is lost or repeated.
`default_nettype none
module projective_point_transform #(
   parameter int FRAC_BITS = ppt_pkg::FracBitsDefault
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [63:0]                           req_tdata,  // point_x, point_y
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [63:0]                                rsp_tdata,  // out_x, out_y
   output logic [1:0]                                 rsp_tuser,  // denom_clamped, saturated
   input  wire logic                                  csr_wr_en,
   input  wire logic [ppt_pkg::CsrIndexWidth-1:0]     csr_index,
   input  wire logic [ppt_pkg::CsrDataWidth-1:0]      csr_wdata
);
   localparam int UW  = 66 - FRAC_BITS;
   localparam int FL  = 3;
   localparam int DL  = ppt_pkg::DivSteps + 2;
   localparam int LAT = FL + DL;
   localparam logic [63:0] One = 64'(1) << FRAC_BITS;

   logic [63:0] col0_ff, col1_ff, trans_ff, proj_ff;
   logic [31:0] corner_ff;
   logic [30:0] mind_ff;
   logic [LAT-1:0] vld_ff;
   logic [DL-1:0]  cl_ff;
   logic en;
   logic [UW-1:0] un_x, un_y, ud;
   logic neg_x, neg_y, clamped;
   logic [31:0] qx, qy;
   logic sx, sy;

   always_ff @(posedge clock) begin
      if (reset) begin
         col0_ff   <= One;
         col1_ff   <= One << 32;
         trans_ff  <= '0;
         proj_ff   <= '0;
         corner_ff <= One[31:0];
         mind_ff   <= 31'd1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            ppt_pkg::CSR_COEF_COL0:       col0_ff   <= csr_wdata;
            ppt_pkg::CSR_COEF_COL1:       col1_ff   <= csr_wdata;
            ppt_pkg::CSR_COEF_TRANSLATE:  trans_ff  <= csr_wdata;
            ppt_pkg::CSR_COEF_PROJECTIVE: proj_ff   <= csr_wdata;
            ppt_pkg::CSR_COEF_CORNER:     corner_ff <= csr_wdata[31:0];
            ppt_pkg::CSR_MIN_DENOMINATOR: mind_ff   <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   assign en         = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cl_ff <= {cl_ff[DL-2:0], clamped};
      end
   end

   ppt_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock           (clock),
      .en              (en),
      .point_x         ($signed(req_tdata[31:0])),
      .point_y         ($signed(req_tdata[63:32])),
      .coef_col0       (col0_ff),
      .coef_col1       (col1_ff),
      .coef_translate  (trans_ff),
      .coef_projective (proj_ff),
      .coef_corner     (corner_ff),
      .min_denominator (mind_ff),
      .un_x            (un_x),
      .un_y            (un_y),
      .ud              (ud),
      .neg_x           (neg_x),
      .neg_y           (neg_y),
      .clamped         (clamped)
   );

   ppt_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
      .clock (clock),
      .en    (en),
      .un    (un_x),
      .ud    (ud),
      .neg   (neg_x),
      .quot  (qx),
      .sat   (sx)
   );

   ppt_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
      .clock (clock),
      .en    (en),
      .un    (un_y),
      .ud    (ud),
      .neg   (neg_y),
      .quot  (qy),
      .sat   (sy)
   );

   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tdata  = {qy, qx};
   assign rsp_tuser  = {sx || sy, cl_ff[DL-1]};

   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready does not follow output stall");

   a_empty_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |->
         rsp_tdata[31:0] == 32'h7FFF_FFFF || rsp_tdata[31:0] == 32'h8000_0000 ||
         rsp_tdata[63:32] == 32'h7FFF_FFFF || rsp_tdata[63:32] == 32'h8000_0000)
      else $error("saturation flag without a limit value");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline moved during a stall");
endmodule
`default_nettype wire
